>>> rtl/ipsd_pkg.sv
package ipsd_pkg;

   // Decoder phase, one per part of the patch file being read.
   typedef enum logic [3:0] {
      PH_HEADER   = 4'd0,
      PH_OFFSET   = 4'd1,
      PH_LENGTH   = 4'd2,
      PH_DATA     = 4'd3,
      PH_RUNCOUNT = 4'd4,
      PH_RUNBYTE  = 4'd5
   } phase_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_WRITE      = 3'd0,
      KIND_FILL       = 3'd1,
      KIND_DONE       = 3'd2,
      KIND_BAD_HEADER = 3'd3,
      KIND_TRUNCATED  = 3'd4
   } kind_type;

   // Input commands.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HEADER_SKIP  = 2'd0;
   localparam logic [1:0] CSR_INITIAL_SIZE = 2'd1;

   localparam int          CSR_INDEX_BITS = 2;
   localparam int          CSR_DATA_BITS  = 25;
   localparam int          ADDR_BITS      = 25;
   localparam int          HEADER_LEN     = 5;
   localparam logic [23:0] EOF_MARK       = 24'h454F46;
   localparam logic [24:0] COPIER_HEADER  = 25'd512;

   // The five header bytes, "PATCH".
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h50;
         3'd1: b = 8'h41;
         3'd2: b = 8'h54;
         3'd3: b = 8'h43;
         3'd4: b = 8'h48;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/ipsd_if.sv
// Input channel: one patch byte or the end command per word.
interface ipsd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] patch_byte;

   modport source (output valid, output command, output patch_byte, input ready);
   modport sink (input valid, input command, input patch_byte, output ready);
endinterface

// Result channel: one write, fill or status report per word.
interface ipsd_rsp_if;
   import ipsd_pkg::*;
   logic               valid;
   logic               ready;
   kind_type           kind;
   logic signed [24:0] address;
   logic [7:0]         data;
   logic [15:0]        fill_count;
   logic [24:0]        image_size;

   modport source (output valid, output kind, output address, output data,
                   output fill_count, output image_size, input ready);
   modport sink (input valid, input kind, input address, input data,
                 input fill_count, input image_size, output ready);
endinterface

>>> rtl/ips_patch_stream_decoder_top.sv
// A result is registered and appears on the rsp channel in the cycle after its word is accepted.
// Throughput: one word per cycle while the input is not stalled; the decoder state and the result register are
// updated in the same cycle as the word is taken.
// Input stalls only while the result register is full and not being taken.
// Reset (synchronous, active high) returns to header checking, clears the copier
// header flag, the image size and the finished flag, and empties the result register.
module ips_patch_stream_decoder_top #(
   parameter int ADDRESS_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ipsd_req_if.sink                              req_chan,
   ipsd_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [ipsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ipsd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import ipsd_pkg::*;

   // Decoder state.
   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [23:0] offset_ff, offset_in;
   logic [15:0] length_ff, length_in;
   logic [24:0] write_address_ff, write_address_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [24:0] size_now_ff, size_now_in;
   logic        finished_ff, finished_in;
   logic        header_skip_ff, header_skip_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic signed [24:0] rsp_address_ff, rsp_address_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic [15:0]        rsp_count_ff, rsp_count_in;
   logic [24:0]        rsp_size_ff, rsp_size_in;

   logic        req_accept;
   logic        step;
   logic        result_load;
   logic [7:0]  b;
   logic        hdr_ok;
   logic        hdr_last;
   logic [23:0] offset_new;
   logic        offset_last;
   logic        is_eof;
   logic [15:0] length_new;
   logic        length_last;
   logic        data_last;
   logic [24:0] record_address;
   logic [15:0] grow_len;
   logic signed [26:0] grow_end;
   logic        grow_hit;

   // A word may enter whenever the result register is empty or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign step           = req_accept && !finished_ff;
   assign b              = req_chan.patch_byte;

   // Shared decode of the current word.
   assign hdr_ok      = (byte_index_ff < 3'(HEADER_LEN)) && (b == magic_byte(byte_index_ff));
   assign hdr_last    = byte_index_ff == 3'(HEADER_LEN - 1);
   assign offset_new  = {offset_ff[15:0], b};
   assign offset_last = byte_index_ff == 3'd2;
   assign is_eof      = offset_new == EOF_MARK;
   assign length_new  = {length_ff[7:0], b};
   assign length_last = byte_index_ff == 3'd1;
   assign data_last   = bytes_left_ff == 16'd1;

   // Record start address, less the copier header when enabled.
   assign record_address = 25'(offset_new[ADDRESS_BITS-1:0])
                           - (header_skip_ff ? COPIER_HEADER : 25'd0);

   // Image growth: signed end of record against the current size.
   assign grow_len = (phase_ff == PH_LENGTH) ? length_new : length_ff;
   assign grow_end = {{2{write_address_ff[24]}}, write_address_ff}
                     + $signed({11'd0, grow_len});
   assign grow_hit = grow_end >= $signed({2'b00, size_now_ff});

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step && req_chan.command == CMD_BYTE) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_ok && hdr_last) phase_in = PH_OFFSET;
            end
            PH_OFFSET: begin
               if (offset_last && !is_eof) phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (length_last) phase_in = (length_new != 16'd0) ? PH_DATA : PH_RUNCOUNT;
            end
            PH_DATA: begin
               if (data_last) phase_in = PH_OFFSET;
            end
            PH_RUNCOUNT: begin
               if (length_last) phase_in = PH_RUNBYTE;
            end
            PH_RUNBYTE: begin
               phase_in = PH_OFFSET;
            end
            default: phase_in = PH_HEADER;
         endcase
      end
   end

   // Datapath, finished flag, results and configuration writes.
   always_comb begin
      byte_index_in    = byte_index_ff;
      offset_in        = offset_ff;
      length_in        = length_ff;
      write_address_in = write_address_ff;
      bytes_left_in    = bytes_left_ff;
      size_now_in      = size_now_ff;
      finished_in      = finished_ff;
      header_skip_in   = header_skip_ff;
      result_load      = 1'b0;
      rsp_kind_in      = KIND_DONE;
      rsp_address_in   = '0;
      rsp_data_in      = '0;
      rsp_count_in     = '0;

      if (step && req_chan.command == CMD_END) begin
         finished_in = 1'b1;
         result_load = 1'b1;
         case (phase_ff)
            PH_HEADER: rsp_kind_in = KIND_BAD_HEADER;
            PH_OFFSET: rsp_kind_in = KIND_DONE;
            default:   rsp_kind_in = KIND_TRUNCATED;
         endcase
      end else if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               if (!hdr_ok) begin
                  finished_in = 1'b1;
                  result_load = 1'b1;
                  rsp_kind_in = KIND_BAD_HEADER;
               end else if (hdr_last) begin
                  byte_index_in = '0;
                  offset_in     = '0;
               end else begin
                  byte_index_in = byte_index_ff + 3'd1;
               end
            end
            PH_OFFSET: begin
               offset_in = offset_new;
               if (!offset_last) begin
                  byte_index_in = byte_index_ff + 3'd1;
               end else begin
                  byte_index_in = '0;
                  if (is_eof) begin
                     finished_in = 1'b1;
                     result_load = 1'b1;
                     rsp_kind_in = KIND_DONE;
                  end else begin
                     write_address_in = record_address;
                     length_in        = '0;
                  end
               end
            end
            PH_LENGTH: begin
               length_in = length_new;
               if (!length_last) begin
                  byte_index_in = byte_index_ff + 3'd1;
               end else begin
                  byte_index_in = '0;
                  if (length_new != 16'd0) begin
                     bytes_left_in = length_new;
                     if (grow_hit) size_now_in = grow_end[24:0];
                  end
               end
            end
            PH_DATA: begin
               result_load      = 1'b1;
               rsp_kind_in      = KIND_WRITE;
               rsp_address_in   = $signed(write_address_ff);
               rsp_data_in      = b;
               write_address_in = write_address_ff + 25'd1;
               bytes_left_in    = bytes_left_ff - 16'd1;
               if (data_last) offset_in = '0;
            end
            PH_RUNCOUNT: begin
               length_in = length_new;
               if (!length_last) byte_index_in = byte_index_ff + 3'd1;
               else byte_index_in = '0;
            end
            PH_RUNBYTE: begin
               if (grow_hit) size_now_in = grow_end[24:0];
               result_load    = 1'b1;
               rsp_kind_in    = KIND_FILL;
               rsp_address_in = $signed(write_address_ff);
               rsp_data_in    = b;
               rsp_count_in   = length_ff;
               offset_in      = '0;
            end
            default: finished_in = 1'b1;
         endcase
      end

      // Configuration must be written only while no word is in flight; the decoder itself does not enforce this.
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER_SKIP:  header_skip_in = csr_wdata[0];
            CSR_INITIAL_SIZE: size_now_in    = csr_wdata;
            default: ;
         endcase
      end

      rsp_size_in  = size_now_in;
      rsp_valid_in = result_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         byte_index_ff  <= '0;
         finished_ff    <= 1'b0;
         header_skip_ff <= 1'b0;
         size_now_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         finished_ff    <= finished_in;
         header_skip_ff <= header_skip_in;
         size_now_ff    <= size_now_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Shift registers and the record address; cleared on reset to match the idle state.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff        <= '0;
         length_ff        <= '0;
         write_address_ff <= '0;
         bytes_left_ff    <= '0;
      end else begin
         offset_ff        <= offset_in;
         length_ff        <= length_in;
         write_address_ff <= write_address_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_address_ff <= rsp_address_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_size_ff    <= rsp_size_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.address    = rsp_address_ff;
   assign rsp_chan.data       = rsp_data_ff;
   assign rsp_chan.fill_count = rsp_count_ff;
   assign rsp_chan.image_size = rsp_size_ff;

   // Once stopped, the decoder produces nothing more.
   a_no_result_after_stop: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !result_load)
      else $error("result produced after the decoder stopped");

   // A status result always stops the decoder.
   a_status_stops: assert property (@(posedge clock) disable iff (reset)
      (result_load && rsp_kind_in != KIND_WRITE && rsp_kind_in != KIND_FILL)
      |=> finished_ff)
      else $error("status result did not stop the decoder");

   // Data phase always has bytes outstanding.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_left_ff != 16'd0))
      else $error("data phase with no bytes left");

   // Offset assembly never runs past three bytes.
   a_offset_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OFFSET) |-> (byte_index_ff < 3'd3))
      else $error("offset byte index out of range");

   // Input stalls only behind a full result register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff)
      else $error("input stalled with an empty result register");

endmodule
